### rtl/avn_pkg.sv
// Shared types and constants for the vertex normal smoothing block.
`timescale 1ns / 1ps
package avn_pkg;
    localparam int ACC_W = 48;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [15:0] q14_t;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_SKIPPED  = 2'd1;
    localparam logic [1:0] ST_FALLBACK = 2'd2;
    localparam logic [1:0] ST_BAD_IDX  = 2'd3;

    localparam q14_t ONE_Q14 = 16'sd16384;
endpackage

### rtl/avn_norm.sv
// Iterative normalization unit: scale, sum of squares, square root, divide.
`timescale 1ns / 1ps
module avn_norm
    import avn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  acc_t vx,
    input  acc_t vy,
    input  acc_t vz,
    output logic done,
    output q14_t nx,
    output q14_t ny,
    output q14_t nz
);
    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_SQRT  = 3'd3;
    localparam logic [2:0] N_DINIT = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [ACC_W-1:0]  m_reg [3];
    logic [ACC_W-1:0]  m_next [3];
    logic [2:0]        neg_reg, neg_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [59:0]       sq_reg, sq_next;
    logic [63:0]       val_reg, val_next;
    logic [63:0]       res_reg, res_next;
    logic [63:0]       bit_reg, bit_next;
    logic [31:0]       len_reg, len_next;
    logic [45:0]       r_reg, r_next;
    logic [45:0]       d_reg, d_next;
    logic [14:0]       q_reg, q_next;
    logic [3:0]        it_reg, it_next;
    q14_t              out_reg [3];
    q14_t              out_next [3];
    logic              done_reg, done_next;
    logic [ACC_W-1:0]  orv;
    logic [15:0]       qc;

    function automatic logic [ACC_W-1:0] mag(input acc_t v);
        return v[ACC_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign orv = m_reg[0] | m_reg[1] | m_reg[2];
    assign qc  = (q_reg > 15'd16384) ? 16'd16384 : {1'b0, q_reg};

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        sq_next    = sq_reg;
        val_next   = val_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        len_next   = len_reg;
        r_next     = r_reg;
        d_next     = d_reg;
        q_next     = q_reg;
        it_next    = it_reg;
        out_next   = out_reg;
        done_next  = 1'b0;
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    m_next[0]  = mag(vx);
                    m_next[1]  = mag(vy);
                    m_next[2]  = mag(vz);
                    neg_next   = {vz[ACC_W-1], vy[ACC_W-1], vx[ACC_W-1]};
                    state_next = N_SHIFT;
                end
            end
            N_SHIFT:
            begin
                // move the largest magnitude's top bit to bit 29, one place a cycle
                if (|orv[ACC_W-1:30])
                begin
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] >> 1;
                end
                else if (!orv[29])
                begin
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] << 1;
                end
                else
                begin
                    cnt_next   = 2'd0;
                    val_next   = '0;
                    state_next = N_SQ;
                end
            end
            N_SQ:
            begin
                if (cnt_reg != 2'd0)
                    val_next = val_reg + {4'd0, sq_reg};
                if (cnt_reg == 2'd3)
                begin
                    res_next   = '0;
                    bit_next   = 64'd1 << 62;
                    state_next = N_SQRT;
                end
                else
                begin
                    sq_next  = m_reg[cnt_reg][29:0] * m_reg[cnt_reg][29:0];
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            N_SQRT:
            begin
                if (bit_reg == '0)
                begin
                    len_next   = res_reg[31:0];
                    cnt_next   = 2'd0;
                    state_next = N_DINIT;
                end
                else
                begin
                    if (val_reg >= res_reg + bit_reg)
                    begin
                        val_next = val_reg - (res_reg + bit_reg);
                        res_next = (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_next = res_reg >> 1;
                    bit_next = bit_reg >> 2;
                end
            end
            N_DINIT:
            begin
                r_next     = ({16'd0, m_reg[cnt_reg][29:0]} << 14) + 46'(len_reg >> 1);
                d_next     = {14'd0, len_reg} << 14;
                q_next     = '0;
                it_next    = 4'd0;
                state_next = N_DIV;
            end
            N_DIV:
            begin
                if (it_reg == 4'd15)
                begin
                    out_next[cnt_reg] = neg_reg[cnt_reg] ? -q14_t'(qc) : q14_t'(qc);
                    if (cnt_reg == 2'd2)
                    begin
                        done_next  = 1'b1;
                        state_next = N_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 2'd1;
                        state_next = N_DINIT;
                    end
                end
                else
                begin
                    if (r_reg >= d_reg)
                    begin
                        r_next = r_reg - d_reg;
                        q_next = {q_reg[13:0], 1'b1};
                    end
                    else
                        q_next = {q_reg[13:0], 1'b0};
                    d_next  = d_reg >> 1;
                    it_next = it_reg + 4'd1;
                end
            end
            default:
                state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        sq_reg  <= sq_next;
        val_reg <= val_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        len_reg <= len_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        it_reg  <= it_next;
        out_reg <= out_next;
    end

    assign done = done_reg;
    assign nx   = out_reg[0];
    assign ny   = out_reg[1];
    assign nz   = out_reg[2];
endmodule

### rtl/area_weighted_vertex_normals.sv
// Top level of the area-weighted vertex normal smoothing block.
`timescale 1ns / 1ps
// Smooth per-vertex normals for a triangle mesh. Pulse start with a word
// while busy is low; exactly one result word follows, shown for one cycle
// with done high, and it must be taken then: the receiver cannot stall.
// A rejected word (skipped triangle, bad slot, unused operation) is answered
// straight from idle, a load makes one write to both memories, a triangle
// does three position reads, six products on two multipliers, then a read
// and a write-back for each corner's accumulator, a read of an all-zero sum
// skips the normalization unit, and any other read waits on that unit:
// one-bit scaling shifts, the squares, a bit-serial square root and a
// divide per component. Busy drops in the cycle that shows done, so the
// next word can be taken at the edge that ends it. Positions are signed
// Q4.12, accumulators saturate at 48 bits, normals come out in Q1.14.
// Memories need no clearing after reset; every vertex must be loaded before
// it is used.
module area_weighted_vertex_normals
    import avn_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [10:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [9:0]         vertex_index,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic [15:0]        corner_a,
    input  logic [15:0]        corner_b,
    input  logic [15:0]        corner_c,
    output logic               done,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic [1:0]         status
);
    localparam int AW  = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam int CB  = COORD_BITS;
    localparam int EW  = CB + 1;
    localparam int PW  = 2 * EW;
    localparam int CRW = PW + 1;
    localparam int PSW = 3 * CB;
    localparam int AXW = 3 * ACC_W;
    localparam logic signed [31:0] C_HI = (32'sd1 <<< (CB - 1)) - 32'sd1;
    localparam logic signed [31:0] C_LO = -C_HI - 32'sd1;
    localparam logic signed [63:0] A_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] A_MIN = -A_MAX - 64'sd1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_RDB   = 4'd3;
    localparam logic [3:0] S_RDC   = 4'd4;
    localparam logic [3:0] S_CAPC  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_ACR   = 4'd7;
    localparam logic [3:0] S_ACW   = 4'd8;
    localparam logic [3:0] S_RDN   = 4'd9;
    localparam logic [3:0] S_ZCHK  = 4'd10;
    localparam logic [3:0] S_NWAIT = 4'd11;

    // position and accumulator memories, registered read
    logic [PSW-1:0] pos_mem [MAX_VERTICES];
    logic [AXW-1:0] acc_mem [MAX_VERTICES];
    logic [PSW-1:0] pos_rdata_reg, pos_wdata;
    logic [AXW-1:0] acc_rdata_reg, acc_wdata;
    logic [AW-1:0]  pos_raddr, acc_raddr, wr_addr;
    logic           pos_we, acc_we;

    logic [3:0]             state_reg, state_next;
    logic [10:0]            vcount_reg;
    logic [15:0]            idx_reg, idx_next;
    logic signed [15:0]     px_reg, py_reg, pz_reg, px_next, py_next, pz_next;
    logic [15:0]            ca_reg, cb_reg, cc_reg, ca_next, cb_next, cc_next;
    logic [PSW-1:0]         pa_reg, pb_reg, pa_next, pb_next;
    logic signed [EW-1:0]   e1_reg [3];
    logic signed [EW-1:0]   e2_reg [3];
    logic signed [EW-1:0]   e1_next [3];
    logic signed [EW-1:0]   e2_next [3];
    logic signed [PW-1:0]   p1_reg, p2_reg, p1_next, p2_next;
    logic signed [CRW-1:0]  cr_reg [3];
    logic signed [CRW-1:0]  cr_next [3];
    logic [1:0]             cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    q14_t                   nx_reg, ny_reg, nz_reg, nx_next, ny_next, nz_next;
    logic [1:0]             st_reg, st_next;

    logic [16:0]      bound;
    logic             idx_bad, tri_bad;
    logic [15:0]      cur_corner;
    logic signed [EW-1:0] ma, mb;
    logic signed [EW-1:0] mc, md;
    acc_t             ax, ay, az;
    logic             norm_start, norm_done;
    q14_t             norm_x, norm_y, norm_z;

    function automatic logic [CB-1:0] clamp_coord(input logic signed [15:0] v);
        logic signed [31:0] s;
        s = 32'(v);
        if (s > C_HI)
            s = C_HI;
        if (s < C_LO)
            s = C_LO;
        return s[CB-1:0];
    endfunction

    function automatic logic signed [EW-1:0] coord(input logic [PSW-1:0] p, input int i);
        return EW'($signed(p[i*CB +: CB]));
    endfunction

    function automatic acc_t sat_add(input acc_t a, input logic signed [CRW-1:0] d);
        logic signed [63:0] s;
        s = 64'(a) + 64'(d);
        if (s > A_MAX)
            s = A_MAX;
        if (s < A_MIN)
            s = A_MIN;
        return s[ACC_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[wr_addr] <= pos_wdata;
        pos_rdata_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[wr_addr] <= acc_wdata;
        acc_rdata_reg <= acc_mem[acc_raddr];
    end

    assign bound   = (17'(vcount_reg) < 17'(MAX_VERTICES)) ? 17'(vcount_reg)
                                                           : 17'(MAX_VERTICES);
    assign idx_bad = 17'(vertex_index) >= 17'(MAX_VERTICES);
    assign tri_bad = (17'(corner_a) >= bound) || (17'(corner_b) >= bound)
                   || (17'(corner_c) >= bound);

    assign cur_corner = (cnt_reg == 2'd0) ? ca_reg : ((cnt_reg == 2'd1) ? cb_reg : cc_reg);
    assign ax = acc_rdata_reg[0*ACC_W +: ACC_W];
    assign ay = acc_rdata_reg[1*ACC_W +: ACC_W];
    assign az = acc_rdata_reg[2*ACC_W +: ACC_W];

    // operand pairs for cross component cnt: e1[j]*e2[k] - e1[k]*e2[j]
    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                ma = e1_reg[1]; mb = e2_reg[2]; mc = e1_reg[2]; md = e2_reg[1];
            end
            2'd1:
            begin
                ma = e1_reg[2]; mb = e2_reg[0]; mc = e1_reg[0]; md = e2_reg[2];
            end
            default:
            begin
                ma = e1_reg[0]; mb = e2_reg[1]; mc = e1_reg[1]; md = e2_reg[0];
            end
        endcase
    end

    // memory addressing follows the sequencer state
    always_comb
    begin
        pos_raddr = ca_reg[AW-1:0];
        case (state_reg)
            S_RDB:   pos_raddr = cb_reg[AW-1:0];
            S_RDC:   pos_raddr = cc_reg[AW-1:0];
            default: pos_raddr = ca_reg[AW-1:0];
        endcase
        acc_raddr = (state_reg == S_RDN) ? idx_reg[AW-1:0] : cur_corner[AW-1:0];
        wr_addr   = (state_reg == S_LOAD) ? idx_reg[AW-1:0] : cur_corner[AW-1:0];
        pos_we    = (state_reg == S_LOAD);
        acc_we    = (state_reg == S_LOAD) || (state_reg == S_ACW);
        pos_wdata = {clamp_coord(pz_reg), clamp_coord(py_reg), clamp_coord(px_reg)};
        if (state_reg == S_LOAD)
            acc_wdata = '0;
        else
            acc_wdata = {sat_add(az, cr_reg[2]), sat_add(ay, cr_reg[1]),
                         sat_add(ax, cr_reg[0])};
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pz_next    = pz_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        cc_next    = cc_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        e1_next    = e1_reg;
        e2_next    = e2_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        cr_next    = cr_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        nz_next    = nz_reg;
        st_next    = st_reg;
        norm_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next = 16'(vertex_index);
                    px_next  = pos_x;
                    py_next  = pos_y;
                    pz_next  = pos_z;
                    ca_next  = corner_a;
                    cb_next  = corner_b;
                    cc_next  = corner_c;
                    nx_next  = '0;
                    ny_next  = '0;
                    nz_next  = '0;
                    st_next  = ST_DONE;
                    case (operation)
                        OP_LOAD:
                        begin
                            if (idx_bad)
                            begin
                                st_next   = ST_BAD_IDX;
                                done_next = 1'b1;
                            end
                            else
                                state_next = S_LOAD;
                        end
                        OP_TRI:
                        begin
                            if (tri_bad)
                            begin
                                st_next   = ST_SKIPPED;
                                done_next = 1'b1;
                            end
                            else
                                state_next = S_RDA;
                        end
                        OP_READ:
                        begin
                            if (idx_bad)
                            begin
                                st_next   = ST_BAD_IDX;
                                done_next = 1'b1;
                            end
                            else
                                state_next = S_RDN;
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            S_LOAD:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_RDA:
                state_next = S_RDB;
            S_RDB:
            begin
                pa_next    = pos_rdata_reg;
                state_next = S_RDC;
            end
            S_RDC:
            begin
                pb_next    = pos_rdata_reg;
                state_next = S_CAPC;
            end
            S_CAPC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_next[i] = coord(pb_reg, i) - coord(pa_reg, i);
                    e2_next[i] = coord(pos_rdata_reg, i) - coord(pa_reg, i);
                end
                cnt_next   = 2'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // products for component cnt, difference for the one before
                p1_next = PW'(ma) * PW'(mb);
                p2_next = PW'(mc) * PW'(md);
                if (cnt_reg != 2'd0)
                    cr_next[cnt_reg - 2'd1] = CRW'(p1_reg) - CRW'(p2_reg);
                if (cnt_reg == 2'd3)
                begin
                    cnt_next   = 2'd0;
                    state_next = S_ACR;
                end
                else
                    cnt_next = cnt_reg + 2'd1;
            end
            S_ACR:
                state_next = S_ACW;
            S_ACW:
            begin
                // write-back lands before the next corner's read is issued
                if (cnt_reg == 2'd2)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 2'd1;
                    state_next = S_ACR;
                end
            end
            S_RDN:
                state_next = S_ZCHK;
            S_ZCHK:
            begin
                if (ax == '0 && ay == '0 && az == '0)
                begin
                    ny_next    = ONE_Q14;
                    st_next    = ST_FALLBACK;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    norm_start = 1'b1;
                    state_next = S_NWAIT;
                end
            end
            S_NWAIT:
            begin
                if (norm_done)
                begin
                    nx_next    = norm_x;
                    ny_next    = norm_y;
                    nz_next    = norm_z;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    avn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vx    (ax),
        .vy    (ay),
        .vz    (az),
        .done  (norm_done),
        .nx    (norm_x),
        .ny    (norm_y),
        .nz    (norm_z)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            vcount_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
                vcount_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
        pz_reg  <= pz_next;
        ca_reg  <= ca_next;
        cb_reg  <= cb_next;
        cc_reg  <= cc_next;
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
        e1_reg  <= e1_next;
        e2_reg  <= e2_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        cr_reg  <= cr_next;
        cnt_reg <= cnt_next;
        nx_reg  <= nx_next;
        ny_reg  <= ny_next;
        nz_reg  <= nz_next;
        st_reg  <= st_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign normal_x = nx_reg;
    assign normal_y = ny_reg;
    assign normal_z = nz_reg;
    assign status   = st_reg;
endmodule
